FILE: hdl/sma_crossover_signal_defines.svh
// Assertion macros used by sma_crossover_signal.sv.
`ifndef SMA_CROSSOVER_SIGNAL_DEFINES_SVH
`define SMA_CROSSOVER_SIGNAL_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/scs_pkg.sv
package scs_pkg;

  localparam int CFG_INDEX_BITS   = 1;
  localparam int CFG_DATA_BITS    = 6;
  localparam int HOLDING_BITS     = 16;
  localparam int QUANTITY_BITS    = 15;
  localparam int ACTION_BITS      = 2;
  localparam int QUEUE_DEPTH      = 8;
  localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_DATA_BITS-1:0] SHORT_PERIOD_RESET = 6'd5;
  localparam logic [CFG_DATA_BITS-1:0] LONG_PERIOD_RESET  = 6'd20;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SHORT_PERIOD = 1'b0,
    REG_LONG_PERIOD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_GT = 2'd1,
    CMP_LT = 2'd2
  } cmp_t;

  typedef struct packed {
    cmp_t                            cmp;
    logic signed [HOLDING_BITS-1:0]  holding;
  } verdict_t;

endpackage

FILE: hdl/scs_front.sv
module scs_front import scs_pkg::*; #(
  parameter int WINDOW_MAX = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PRICE_BITS-1:0]           close_price,
  input  logic signed [HOLDING_BITS-1:0]  holding,
  input  logic [QUEUE_LEVEL_BITS-1:0]     q_level,
  output logic [1:0]                      inflight,
  output logic                            push,
  output verdict_t                        push_verdict,
  output logic [PRICE_BITS-1:0]           push_price
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int PW = $clog2(WINDOW_MAX + 1);
  localparam int SW = PRICE_BITS + $clog2(WINDOW_MAX);
  localparam int MW = SW + PW;
  localparam int LW = QUEUE_LEVEL_BITS + 1;

  function automatic logic [PW-1:0] eff_period(input logic [CFG_DATA_BITS-1:0] r);
    logic [PW-1:0] p;
    if (r == '0) begin
      p = PW'(1);
    end else if (32'(r) > WINDOW_MAX) begin
      p = PW'(WINDOW_MAX);
    end else begin
      p = PW'(r);
    end
    return p;
  endfunction

  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] w, input logic [PW-1:0] n);
    logic [AW:0] t;
    t = {1'b0, w} + (AW+1)'(WINDOW_MAX) - (AW+1)'(n);
    if (32'(t) >= WINDOW_MAX) begin
      t = t - (AW+1)'(WINDOW_MAX);
    end
    return AW'(t);
  endfunction

  logic [CFG_DATA_BITS-1:0] short_period, long_period;
  logic [PW-1:0]            sp, lp;

  logic [AW-1:0]            wp, wp_next;
  logic [PW-1:0]            fill_count, fill_next;
  logic [AW-1:0]            ra_short, ra_long;
  logic                     accept;

  logic [PRICE_BITS-1:0]    ring [WINDOW_MAX];

  logic                     s1_valid;
  logic [PRICE_BITS-1:0]    s1_price, s1_old_short, s1_old_long;
  logic signed [HOLDING_BITS-1:0] s1_holding;
  logic                     s1_drop_short, s1_drop_long, s1_emit;
  logic [PW-1:0]            s1_short_count;

  logic [SW-1:0]            short_sum, long_sum, short_sum_next, long_sum_next;

  logic                     s2_valid;
  logic [PRICE_BITS-1:0]    s2_price;
  logic signed [HOLDING_BITS-1:0] s2_holding;
  logic [PW-1:0]            s2_short_count;

  logic                     s3_valid;
  logic [PRICE_BITS-1:0]    s3_price;
  logic signed [HOLDING_BITS-1:0] s3_holding;
  logic [MW-1:0]            s3_prod_short, s3_prod_long;

  logic [LW-1:0]            level_total;

  assign sp = eff_period(short_period);
  assign lp = eff_period(long_period);

  assign inflight    = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);
  assign level_total = LW'(q_level) + LW'(inflight);
  assign in_ready    = level_total < LW'(QUEUE_DEPTH);
  assign accept      = in_valid && in_ready;

  assign ra_short  = back_addr(wp, sp);
  assign ra_long   = back_addr(wp, lp);
  assign wp_next   = (32'(wp) == WINDOW_MAX - 1) ? '0 : wp + 1'b1;
  assign fill_next = (fill_count < PW'(WINDOW_MAX)) ? fill_count + 1'b1 : fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_period <= SHORT_PERIOD_RESET;
      long_period  <= LONG_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHORT_PERIOD: short_period <= cfg_data;
        REG_LONG_PERIOD:  long_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      wp         <= '0;
      fill_count <= '0;
    end else if (accept) begin
      wp         <= wp_next;
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp]     <= close_price;
      s1_old_short <= ring[ra_short];
      s1_old_long  <= ring[ra_long];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_price       <= close_price;
      s1_holding     <= holding;
      s1_drop_short  <= fill_count >= sp;
      s1_drop_long   <= fill_count >= lp;
      s1_emit        <= fill_next >= lp;
      s1_short_count <= (fill_next < sp) ? fill_next : sp;
    end
  end

  always_comb begin
    short_sum_next = short_sum + SW'(s1_price);
    long_sum_next  = long_sum + SW'(s1_price);
    if (s1_drop_short) begin
      short_sum_next = short_sum_next - SW'(s1_old_short);
    end
    if (s1_drop_long) begin
      long_sum_next = long_sum_next - SW'(s1_old_long);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      short_sum <= '0;
      long_sum  <= '0;
    end else if (s1_valid) begin
      short_sum <= short_sum_next;
      long_sum  <= long_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_price       <= s1_price;
    s2_holding     <= s1_holding;
    s2_short_count <= s1_short_count;
    s3_price       <= s2_price;
    s3_holding     <= s2_holding;
    s3_prod_short  <= MW'(short_sum) * MW'(lp);
    s3_prod_long   <= MW'(long_sum) * MW'(s2_short_count);
  end

  always_comb begin
    push_verdict.holding = s3_holding;
    if (s3_prod_short > s3_prod_long) begin
      push_verdict.cmp = CMP_GT;
    end else if (s3_prod_short < s3_prod_long) begin
      push_verdict.cmp = CMP_LT;
    end else begin
      push_verdict.cmp = CMP_EQ;
    end
  end

  assign push       = s3_valid;
  assign push_price = s3_price;

endmodule

FILE: hdl/scs_queue.sv
module scs_queue import scs_pkg::*; #(
  parameter int DATA_BITS = 50
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [DATA_BITS-1:0]         push_data,
  input  logic                         pop,
  output logic [DATA_BITS-1:0]         pop_data,
  output logic                         valid,
  output logic [QUEUE_LEVEL_BITS-1:0]  level
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  logic [DATA_BITS-1:0] slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  rd_ptr, wr_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + QUEUE_LEVEL_BITS'(push) - QUEUE_LEVEL_BITS'(pop);
    end
  end

  assign pop_data = slots[rd_ptr];
  assign valid    = level != '0;

endmodule

FILE: hdl/scs_back.sv
module scs_back import scs_pkg::*; #(
  parameter int PRICE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  verdict_t                  q_verdict,
  input  logic [PRICE_BITS-1:0]     q_price,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ACTION_BITS-1:0]    action,
  output logic [QUANTITY_BITS-1:0]  quantity,
  output logic [PRICE_BITS-1:0]     trade_price
);

  action_t                  act_next;
  logic [QUANTITY_BITS-1:0] qty_next;
  logic                     flat, long_position;

  assign q_pop = q_valid && (!out_valid || out_ready);

  assign flat          = q_verdict.holding == '0;
  assign long_position = !q_verdict.holding[HOLDING_BITS-1] && !flat;

  always_comb begin
    act_next = ACT_HOLD;
    qty_next = '0;
    if (q_verdict.cmp == CMP_GT && flat) begin
      act_next = ACT_BUY;
      qty_next = QUANTITY_BITS'(1);
    end else if (q_verdict.cmp == CMP_LT && long_position) begin
      act_next = ACT_SELL;
      qty_next = q_verdict.holding[QUANTITY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      action      <= act_next;
      quantity    <= qty_next;
      trade_price <= q_price;
    end
  end

endmodule

FILE: hdl/sma_crossover_signal.sv
// Moving-average crossover signal. One closing price (unsigned Q24.8) and the
// current holding enter per request; the block keeps the last prices in a
// ring and running sums over the short and long windows, and once the long
// window has filled it returns one decision per request: buy 1 share when the
// short average is above the long one and the holding is zero, sell the whole
// holding when it is below and the holding is positive, hold otherwise. The
// first N - 1 requests after reset or after any period write return nothing,
// N being long_period clamped to 1..WINDOW_MAX. A new request is taken every
// clock cycle while in_ready is high; this rate is set by the price ring,
// written once and read twice per cycle, and by the one add and subtract per
// window sum. A decision passes s1, s2, s3 and an 8-entry queue to the output
// register; the queue lets the input keep flowing while the output stalls.
// Write the period registers only while no request is in flight.
`include "sma_crossover_signal_defines.svh"

module sma_crossover_signal import scs_pkg::*; #(
  parameter int WINDOW_MAX = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PRICE_BITS-1:0]           close_price,
  input  logic signed [HOLDING_BITS-1:0]  holding,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ACTION_BITS-1:0]          action,
  output logic [QUANTITY_BITS-1:0]        quantity,
  output logic [PRICE_BITS-1:0]           trade_price
);

  localparam int QDW = $bits(verdict_t) + PRICE_BITS;

  logic                         q_push, q_pop, q_valid;
  logic [QUEUE_LEVEL_BITS-1:0]  q_level;
  logic [1:0]                   inflight;
  verdict_t                     push_verdict, q_verdict;
  logic [PRICE_BITS-1:0]        push_price, q_price;
  logic [QDW-1:0]               q_data;

  scs_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .close_price  (close_price),
    .holding      (holding),
    .q_level      (q_level),
    .inflight     (inflight),
    .push         (q_push),
    .push_verdict (push_verdict),
    .push_price   (push_price)
  );

  scs_queue #(
    .DATA_BITS (QDW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_verdict, push_price}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .valid     (q_valid),
    .level     (q_level)
  );

  assign q_verdict = verdict_t'(q_data[QDW-1:PRICE_BITS]);
  assign q_price   = q_data[PRICE_BITS-1:0];

  scs_back #(
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_verdict   (q_verdict),
    .q_price     (q_price),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .quantity    (quantity),
    .trade_price (trade_price)
  );

  `SCS_ASSERT_IMP(a_queue_no_overflow, q_push && !q_pop, 32'(q_level) < QUEUE_DEPTH, "queue overflow")
  `SCS_ASSERT_IMP(a_queue_no_underflow, q_pop, q_level != '0, "queue underflow")
  `SCS_ASSERT_NEXT(a_credit_bound, in_valid && in_ready, 32'(q_level) + 32'(inflight) <= QUEUE_DEPTH, "credit exceeded")
  `SCS_ASSERT_IMP(a_sell_nonzero, out_valid && action == ACT_SELL, quantity != '0, "empty sell")

endmodule
